>>> hw/rtl/wph_pkg.sv
package wph_pkg;

  // Channel payload widths fixed by the item format
  localparam int BEAT_W  = 64;
  localparam int BLOCK_W = 16;

  // Configuration register widths
  localparam int BPB_W = 16;
  localparam int TOL_W = 10;

  // APB port geometry: three 32-bit registers at byte addresses 0, 4, 8
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BEATS_PER_BAR     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE_SAMPLES = 2'd2;

  // Reset values
  localparam logic [CFG_DATA_W-1:0] LEN_RESET = 32'd88200;
  localparam logic [BPB_W-1:0]      BPB_RESET = 16'd1024;
  localparam logic [TOL_W-1:0]      TOL_RESET = 10'd88;

endpackage

>>> hw/rtl/wph_in_if.sv
interface wph_in_if;
  logic                              valid;
  logic                              ready;
  logic                              host_playing;
  logic                              host_has_beat;
  logic signed [wph_pkg::BEAT_W-1:0] beat_position;
  logic [wph_pkg::BLOCK_W-1:0]       block_samples;

  modport source (
    output valid, host_playing, host_has_beat, beat_position, block_samples,
    input  ready
  );

  modport sink (
    input  valid, host_playing, host_has_beat, beat_position, block_samples,
    output ready
  );
endinterface

>>> hw/rtl/wph_out_if.sv
interface wph_out_if #(
  parameter int POSITION_WIDTH = 21
);
  logic                      valid;
  logic                      ready;
  logic [POSITION_WIDTH-1:0] render_position;
  logic                      resynced;

  modport source (
    output valid, render_position, resynced,
    input  ready
  );

  modport sink (
    input  valid, render_position, resynced,
    output ready
  );
endinterface

>>> hw/rtl/wrapping_playhead_with_host_resync_core.sv
// Steps per accepted item with a beat: reduce the beat modulo the bar length, scale the bar
//   fraction by the length (round half up, wrap), reduce the playhead modulo the length, check
//   the tolerance and snap, advance by the block size. Zero beats per bar targets 0; without a
//   beat no snap check; zero length goes straight to done with result 0. One item at a time:
//   ready only in idle; the shared compare-subtract unit takes one step a cycle; a held result adds its stall.
// Reset (synchronous, rst_n low): playhead 0, idle, output empty, registers 88200/1024/88.
module wrapping_playhead_with_host_resync_core #(
  parameter int POSITION_WIDTH     = 21,
  parameter int BEAT_FRACTION_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wph_in_if.sink                             in_ch,
  wph_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wph_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wph_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wph_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import wph_pkg::*;

  localparam int PW     = POSITION_WIDTH;
  localparam int DW     = BEAT_W;
  localparam int MW     = BEAT_FRACTION_BITS + 8;
  localparam int UW     = (MW + 1 > PW + 1) ? MW + 1 : PW + 1;
  localparam int AW     = ((PW > BLOCK_W) ? PW : BLOCK_W) + 1;
  localparam int CNT_W  = $clog2(DW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BMOD, S_BNEG, S_PROD, S_ROUND, S_WRAP,
    S_PMOD, S_DIST, S_SNAP, S_ALOAD, S_ADV, S_DONE
  } state_t;

  // Configuration
  logic [PW-1:0]    len;
  logic [BPB_W-1:0] bpb;
  logic [TOL_W-1:0] tol;
  logic [MW-1:0]    m_w;

  wph_cfg #(.POSITION_WIDTH(PW)) u_cfg (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .pattern_length    (len),
    .beats_per_bar     (bpb),
    .tolerance_samples (tol)
  );

  // Bar length in beat-position units
  assign m_w = MW'(bpb) << (BEAT_FRACTION_BITS - 8);

  state_t             state_r, state_nxt;
  logic [UW-1:0]      rem_r, rem_nxt;
  logic [DW-1:0]      dvd_r, dvd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MW-1:0]      r_r, r_nxt;
  logic [PW-1:0]      q_r, q_nxt;
  logic [PW-1:0]      tgt_r, tgt_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]      ad_r, ad_nxt;
  logic [PW-1:0]      playhead_r, playhead_nxt;
  logic [BLOCK_W-1:0] block_r, block_nxt;
  logic               half_r, half_nxt;
  logic               neg_r, neg_nxt;
  logic               sync_r, sync_nxt;
  logic               snap_r, snap_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PW-1:0]      render_r, render_nxt;
  logic               resynced_r, resynced_nxt;

  logic [UW-1:0] cand_w, dsor_w, csu_diff, rem_step;
  logic          csu_ge;
  logic [DW-1:0] beat_u;
  logic [AW-1:0] adv_sum;
  logic          accept;

  assign accept = in_ch.valid & in_ch.ready;
  assign beat_u = in_ch.beat_position;
  assign adv_sum = AW'(pos_r) + AW'(block_r);

  // Route operands into the shared unit
  always_comb begin
    cand_w = '0;
    dsor_w = '0;
    case (state_r)
      S_BMOD: begin
        cand_w = UW'({rem_r[MW-1:0], dvd_r[DW-1]});
        dsor_w = UW'(m_w);
      end
      S_BNEG: begin
        cand_w = UW'(m_w);
        dsor_w = rem_r;
      end
      S_PROD: begin
        cand_w = half_r ? (UW'(rem_r[MW-1:0]) + UW'(r_r)) : UW'({rem_r[MW-1:0], 1'b0});
        dsor_w = UW'(m_w);
      end
      S_ROUND: begin
        cand_w = UW'({rem_r[MW-1:0], 1'b0});
        dsor_w = UW'(m_w);
      end
      S_WRAP: begin
        cand_w = UW'(q_r);
        dsor_w = UW'(len);
      end
      S_PMOD, S_ADV: begin
        cand_w = UW'({rem_r[PW-1:0], dvd_r[DW-1]});
        dsor_w = UW'(len);
      end
      S_DIST: begin
        cand_w = UW'(tgt_r);
        dsor_w = UW'(pos_r);
      end
      S_SNAP: begin
        cand_w = UW'(len);
        dsor_w = UW'(ad_r);
      end
      default: ;
    endcase
  end

  wph_csu #(.WIDTH(UW)) u_csu (
    .cand (cand_w),
    .dsor (dsor_w),
    .diff (csu_diff),
    .ge   (csu_ge)
  );

  assign rem_step = csu_ge ? csu_diff : cand_w;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    cnt_nxt       = cnt_r;
    r_nxt         = r_r;
    q_nxt         = q_r;
    tgt_nxt       = tgt_r;
    pos_nxt       = pos_r;
    ad_nxt        = ad_r;
    playhead_nxt  = playhead_r;
    block_nxt     = block_r;
    half_nxt      = half_r;
    neg_nxt       = neg_r;
    sync_nxt      = sync_r;
    snap_nxt      = snap_r;
    render_nxt    = render_r;
    resynced_nxt  = resynced_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          block_nxt = in_ch.block_samples;
          sync_nxt  = in_ch.host_playing & in_ch.host_has_beat;
          snap_nxt  = 1'b0;
          if (len == '0) begin
            // Zero length forces the playhead and the result to zero
            pos_nxt      = '0;
            playhead_nxt = '0;
            state_nxt    = S_DONE;
          end else if (in_ch.host_playing && in_ch.host_has_beat && m_w != '0) begin
            // Reduce the beat magnitude modulo the bar length
            neg_nxt   = beat_u[DW-1];
            dvd_nxt   = beat_u[DW-1] ? (~beat_u + DW'(1)) : beat_u;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(DW);
            state_nxt = S_BMOD;
          end else begin
            tgt_nxt   = '0;
            rem_nxt   = '0;
            dvd_nxt   = DW'(playhead_r) << (DW - PW);
            cnt_nxt   = CNT_W'(PW);
            state_nxt = S_PMOD;
          end
        end
      end

      S_BMOD: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) state_nxt = S_BNEG;
      end

      S_BNEG: begin
        // Floor modulo: a negative position counts back from the bar end
        r_nxt     = (neg_r && rem_r != '0) ? csu_diff[MW-1:0] : rem_r[MW-1:0];
        rem_nxt   = '0;
        q_nxt     = '0;
        half_nxt  = 1'b0;
        dvd_nxt   = DW'(len) << (DW - PW);
        cnt_nxt   = CNT_W'(PW);
        state_nxt = S_PROD;
      end

      S_PROD: begin
        // Shift-and-add divmod of r * length by the bar length
        rem_nxt = rem_step;
        if (!half_r) begin
          q_nxt = {q_r[PW-2:0], csu_ge};
        end else begin
          q_nxt = q_r + PW'(csu_ge);
        end
        if (!half_r && dvd_r[DW-1]) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          dvd_nxt  = {dvd_r[DW-2:0], 1'b0};
          cnt_nxt  = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) state_nxt = S_ROUND;
        end
      end

      S_ROUND: begin
        // Round half up
        q_nxt     = q_r + PW'(csu_ge);
        state_nxt = S_WRAP;
      end

      S_WRAP: begin
        tgt_nxt   = csu_ge ? csu_diff[PW-1:0] : q_r;
        rem_nxt   = '0;
        dvd_nxt   = DW'(playhead_r) << (DW - PW);
        cnt_nxt   = CNT_W'(PW);
        state_nxt = S_PMOD;
      end

      S_PMOD: begin
        // Reduce the playhead modulo the length
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          pos_nxt   = rem_step[PW-1:0];
          state_nxt = sync_r ? S_DIST : S_ALOAD;
        end
      end

      S_DIST: begin
        ad_nxt    = csu_ge ? csu_diff[PW-1:0] : (pos_r - tgt_r);
        state_nxt = S_SNAP;
      end

      S_SNAP: begin
        // Snap when both ways round the loop exceed the tolerance
        if (ad_r > PW'(tol) && csu_diff[PW-1:0] > PW'(tol)) begin
          pos_nxt  = tgt_r;
          snap_nxt = 1'b1;
        end
        state_nxt = S_ALOAD;
      end

      S_ALOAD: begin
        rem_nxt   = '0;
        dvd_nxt   = DW'(adv_sum) << (DW - AW);
        cnt_nxt   = CNT_W'(AW);
        state_nxt = S_ADV;
      end

      S_ADV: begin
        // Advance by the block size modulo the length
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          playhead_nxt = rem_step[PW-1:0];
          state_nxt    = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          render_nxt    = pos_r;
          resynced_nxt  = snap_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      playhead_r  <= '0;
      sync_r      <= 1'b0;
      snap_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      playhead_r  <= playhead_nxt;
      sync_r      <= sync_nxt;
      snap_r      <= snap_nxt;
    end
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    cnt_r      <= cnt_nxt;
    r_r        <= r_nxt;
    q_r        <= q_nxt;
    tgt_r      <= tgt_nxt;
    pos_r      <= pos_nxt;
    ad_r       <= ad_nxt;
    block_r    <= block_nxt;
    half_r     <= half_nxt;
    neg_r      <= neg_nxt;
    render_r   <= render_nxt;
    resynced_r <= resynced_nxt;
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.render_position = render_r;
  assign out_ch.resynced        = resynced_r;

  // An accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("sequencer stayed idle after accepting an item");

  // A new result appears only from the done step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

  // Iteration counter never runs out inside a loop
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BMOD || state_r == S_PROD || state_r == S_PMOD || state_r == S_ADV)
      |-> cnt_r != '0)
    else $error("iteration counter empty inside a loop");

  // A snap needs a host beat
  a_snap_sync: assert property (@(posedge clk) disable iff (!rst_n)
    snap_r |-> sync_r)
    else $error("snap without host beat");

endmodule

>>> hw/rtl/wph_csu.sv
// Shared compare-subtract unit: one restoring step per use
module wph_csu #(
  parameter int WIDTH = 42
) (
  input  logic [WIDTH-1:0] cand,
  input  logic [WIDTH-1:0] dsor,
  output logic [WIDTH-1:0] diff,
  output logic             ge
);

  logic [WIDTH:0] full_diff;

  // Subtract with borrow out; no borrow means cand >= dsor
  assign full_diff = {1'b0, cand} - {1'b0, dsor};
  assign diff      = full_diff[WIDTH-1:0];
  assign ge        = ~full_diff[WIDTH];

endmodule

>>> hw/rtl/wph_cfg.sv
module wph_cfg #(
  parameter int POSITION_WIDTH = 21
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wph_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wph_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wph_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [POSITION_WIDTH-1:0]          pattern_length,
  output logic [wph_pkg::BPB_W-1:0]          beats_per_bar,
  output logic [wph_pkg::TOL_W-1:0]          tolerance_samples
);
  import wph_pkg::*;

  logic [POSITION_WIDTH-1:0] len_r;
  logic [BPB_W-1:0]          bpb_r;
  logic [TOL_W-1:0]          tol_r;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic                      wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET[POSITION_WIDTH-1:0];
      bpb_r <= BPB_RESET;
      tol_r <= TOL_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_LENGTH:    len_r <= pwdata[POSITION_WIDTH-1:0];
        REG_BEATS_PER_BAR:     bpb_r <= pwdata[BPB_W-1:0];
        REG_TOLERANCE_SAMPLES: tol_r <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LENGTH:    prdata = CFG_DATA_W'(len_r);
      REG_BEATS_PER_BAR:     prdata = CFG_DATA_W'(bpb_r);
      REG_TOLERANCE_SAMPLES: prdata = CFG_DATA_W'(tol_r);
      default:               prdata = '0;
    endcase
  end

  assign pattern_length    = len_r;
  assign beats_per_bar     = bpb_r;
  assign tolerance_samples = tol_r;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import wph_pkg::*;

  localparam int POS_W       = 21;
  localparam int FRAC_BITS   = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SHOW_LIMIT  = 10;

  typedef struct packed {
    logic                     playing;
    logic                     has_beat;
    logic signed [BEAT_W-1:0] beat;
    logic [BLOCK_W-1:0]       samples;
  } block_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             resync;
  } render_t;

  typedef enum logic {ROW_WRITE, ROW_BLOCK} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [REG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] value;
    block_t                blk;
    logic                  typed;
    render_t               want;
  } row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  wph_in_if in_ch ();
  wph_out_if #(.POSITION_WIDTH(POS_W)) out_ch ();

  wrapping_playhead_with_host_resync_core #(
    .POSITION_WIDTH(POS_W),
    .BEAT_FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Playhead predictor state and its copy of the registers
  logic [POS_W-1:0] cfg_len;
  logic [BPB_W-1:0] cfg_bpb;
  logic [TOL_W-1:0] cfg_tol;
  logic [POS_W-1:0] head_pos;

  render_t expected_renders[$];
  row_t    directed_rows[$];
  int      mismatch_count;
  int      cycle_count;
  bit      calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // One bar in units of the beat position's fraction
  function automatic bit [63:0] bar_span();
    return 64'(cfg_bpb) << (FRAC_BITS - 8);
  endfunction

  // Work out the render position of one block and move the playhead past it
  function automatic render_t advance_playhead(block_t b);
    render_t        r;
    bit [63:0]      bar, beat_u, off, prod, quo, rem, aim, next_head;
    longint signed  drift, span;
    logic [POS_W-1:0] pos;
    r = '0;
    if (cfg_len == 0) begin
      head_pos = '0;
      return r;
    end
    pos = head_pos % cfg_len;
    if (b.playing && b.has_beat) begin
      aim = 0;
      bar = bar_span();
      if (bar != 0) begin
        // floor modulo of the beat position by one bar
        beat_u = b.beat;
        if (!beat_u[63]) begin
          off = beat_u % bar;
        end else begin
          off = (-beat_u) % bar;
          if (off != 0) off = bar - off;
        end
        // scale the bar fraction to samples, round half up, wrap
        prod = off * 64'(cfg_len);
        quo  = prod / bar;
        rem  = prod % bar;
        if (2 * rem >= bar) quo++;
        if (quo >= 64'(cfg_len)) quo -= 64'(cfg_len);
        aim = quo;
      end
      // shortest circular drift, half a length counts as negative
      span  = longint'(cfg_len);
      drift = longint'(aim) - longint'(pos);
      if (2 * drift >= span) drift -= span;
      else if (2 * drift < -span) drift += span;
      if (drift < 0) drift = -drift;
      if (drift > longint'(cfg_tol)) begin
        pos      = aim[POS_W-1:0];
        r.resync = 1'b1;
      end
    end
    r.pos     = pos;
    next_head = (64'(pos) + 64'(b.samples)) % 64'(cfg_len);
    head_pos  = next_head[POS_W-1:0];
    return r;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Random block: mostly a playing host, often aimed near the playhead
  function automatic block_t draw_block();
    block_t        b;
    longint signed bar, aim, span, k;
    int unsigned   kind, tol_i;
    kind       = $urandom_range(0, 9);
    b.playing  = (kind < 8) ? 1'b1 : 1'($urandom_range(0, 1));
    b.has_beat = (kind < 8) ? 1'b1 : 1'($urandom_range(0, 1));
    b.beat     = {$urandom, $urandom};
    b.samples  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 2048));
    bar  = longint'(bar_span());
    span = longint'(cfg_len);
    if (kind < 5 && span != 0 && bar != 0) begin
      tol_i = cfg_tol;
      aim   = longint'(head_pos % cfg_len) + longint'($urandom_range(0, 2 * tol_i + 4))
              - longint'(tol_i) - 2;
      aim   = ((aim % span) + span) % span;
      k     = longint'($urandom_range(0, 2000)) - 1000;
      b.beat = (aim * bar) / span + k * bar;
    end
    return b;
  endfunction

  function automatic void add_write(logic [REG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] value);
    row_t row;
    row.kind    = ROW_WRITE;
    row.reg_sel = sel;
    row.value   = value;
    row.blk     = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_block(logic playing, logic has_beat, logic [63:0] beat,
                                    logic [15:0] samples, logic typed,
                                    logic [POS_W-1:0] pos, logic resync);
    row_t row;
    row.kind    = ROW_BLOCK;
    row.reg_sel = '0;
    row.value   = '0;
    row.blk     = '{playing, has_beat, beat, samples};
    row.typed   = typed;
    row.want    = '{pos, resync};
    directed_rows.push_back(row);
  endfunction

  // APB write: setup cycle, then access cycle until pready
  task automatic write_register(input logic [REG_IDX_W-1:0] sel,
                                input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_PATTERN_LENGTH:    cfg_len = value[POS_W-1:0];
      REG_BEATS_PER_BAR:     cfg_bpb = value[BPB_W-1:0];
      REG_TOLERANCE_SAMPLES: cfg_tol = value[TOL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid and wait until every expected render has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_renders.size() != 0) @(posedge clk);
  endtask

  // Offer one block, hold it until accepted, then record its render
  task automatic send_block(input block_t b, input logic typed, input render_t want);
    int      gap;
    render_t got;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.host_playing  <= b.playing;
    in_ch.host_has_beat <= b.has_beat;
    in_ch.beat_position <= b.beat;
    in_ch.block_samples <= b.samples;
    do @(posedge clk); while (!in_ch.ready);
    got = advance_playhead(b);
    expected_renders.push_back(typed ? want : got);
  endtask

  // Result side: stall at random, then accept one item
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare each accepted render with the oldest expectation
  always @(posedge clk) begin
    render_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_renders.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("unexpected render: pos %0d resync %0b",
                   out_ch.render_position, out_ch.resynced);
      end else begin
        want = expected_renders.pop_front();
        if (out_ch.render_position !== want.pos || out_ch.resynced !== want.resync) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("render mismatch: expected pos %0d resync %0b, got pos %0d resync %0b",
                     want.pos, want.resync, out_ch.render_position, out_ch.resynced);
        end
      end
    end
  end

  initial begin
    row_t                  row;
    logic [CFG_DATA_W-1:0] len_pick, bpb_pick, tol_pick;
    block_t                b;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.host_playing  <= 1'b0;
    in_ch.host_has_beat <= 1'b0;
    in_ch.beat_position <= '0;
    in_ch.block_samples <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    cfg_len             = LEN_RESET[POS_W-1:0];
    cfg_bpb             = BPB_RESET;
    cfg_tol             = TOL_RESET;
    head_pos            = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: 88200 samples, four beats per bar, tolerance 88
    add_block(1'b0, 1'b0, 64'h0, 16'd1000, 1'b1, 21'd0, 1'b0);
    add_block(1'b1, 1'b1, 64'h0, 16'd0, 1'b1, 21'd0, 1'b1);
    add_block(1'b1, 1'b1, 64'h0, 16'd88, 1'b1, 21'd0, 1'b0);
    // drift equal to the tolerance holds, one more snaps
    add_block(1'b1, 1'b1, 64'h0, 16'd1, 1'b1, 21'd88, 1'b0);
    add_block(1'b1, 1'b1, 64'h0, 16'd0, 1'b1, 21'd0, 1'b1);
    // half a bar away: the tie goes negative and still snaps
    add_block(1'b1, 1'b1, 64'h2_0000_0000, 16'd0, 1'b1, 21'd44100, 1'b1);
    // negative beat wraps into the last quarter of the bar
    add_block(1'b1, 1'b1, 64'hFFFF_FFFF_0000_0000, 16'hFFFF, 1'b1, 21'd66150, 1'b1);
    // rounding exactly at half, just under it, and a target that wraps to 0
    add_block(1'b1, 1'b1, 64'h4000_0000, 16'd0, 1'b0, '0, 1'b0);
    add_block(1'b1, 1'b1, 64'h3FFF_FFFF, 16'd0, 1'b0, '0, 1'b0);
    add_block(1'b1, 1'b1, 64'h3_FFFF_FFFF, 16'd0, 1'b0, '0, 1'b0);
    add_block(1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 16'd0, 1'b0, '0, 1'b0);
    add_block(1'b1, 1'b1, 64'h8000_0000_0000_0000, 16'hFFFF, 1'b0, '0, 1'b0);
    // no beat, or not playing: never resync
    add_block(1'b1, 1'b0, 64'h2_0000_0000, 16'd12345, 1'b0, '0, 1'b0);
    add_block(1'b0, 1'b1, 64'h2_0000_0000, 16'd0, 1'b0, '0, 1'b0);
    // zero length pins everything to 0
    add_write(REG_PATTERN_LENGTH, 32'd0);
    add_block(1'b1, 1'b1, 64'h1_0000_0000, 16'd500, 1'b1, 21'd0, 1'b0);
    add_write(REG_PATTERN_LENGTH, 32'd100);
    add_block(1'b0, 1'b0, 64'h0, 16'd250, 1'b1, 21'd0, 1'b0);
    add_block(1'b0, 1'b0, 64'h0, 16'd0, 1'b1, 21'd50, 1'b0);
    // shrink the length below the playhead
    add_write(REG_PATTERN_LENGTH, 32'd30);
    add_block(1'b0, 1'b0, 64'h0, 16'd0, 1'b1, 21'd20, 1'b0);
    // zero beats per bar targets 0
    add_write(REG_BEATS_PER_BAR, 32'd0);
    add_write(REG_TOLERANCE_SAMPLES, 32'd0);
    add_block(1'b1, 1'b1, 64'h0123_4567_89AB_CDEF, 16'd0, 1'b1, 21'd0, 1'b1);
    // all registers at their top
    add_write(REG_PATTERN_LENGTH, 32'd2097151);
    add_write(REG_BEATS_PER_BAR, 32'd65535);
    add_write(REG_TOLERANCE_SAMPLES, 32'd1023);
    add_block(1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0, '0, 1'b0);
    add_block(1'b1, 1'b1, 64'h8000_0000_0000_0000, 16'hFFFF, 1'b0, '0, 1'b0);
    add_block(1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 1'b0, '0, 1'b0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_register(row.reg_sel, row.value);
      end else begin
        send_block(row.blk, row.typed, row.want);
      end
    end

    // Random phases, each under fresh register settings
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 9))
        0:       len_pick = 32'd0;
        1, 2:    len_pick = $urandom_range(1, 64);
        3:       len_pick = 32'd2097151;
        4, 5, 6: len_pick = $urandom_range(1, 200000);
        default: len_pick = $urandom_range(1, 2097151);
      endcase
      case ($urandom_range(0, 7))
        0:       bpb_pick = 32'd0;
        1:       bpb_pick = 32'd65535;
        2:       bpb_pick = 32'd1;
        3, 4, 5: bpb_pick = 256 * $urandom_range(1, 16);
        default: bpb_pick = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 5))
        0:       tol_pick = 32'd0;
        1:       tol_pick = 32'd1023;
        default: tol_pick = $urandom_range(0, 1023);
      endcase
      settle();
      write_register(REG_PATTERN_LENGTH, len_pick);
      write_register(REG_BEATS_PER_BAR, bpb_pick);
      write_register(REG_TOLERANCE_SAMPLES, tol_pick);
      for (int n = 0; n < 75; n++) begin
        if (n % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        b = draw_block();
        send_block(b, 1'b0, '0);
      end
    end

    // Drain, then watch for stray results
    settle();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_renders.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
